// ----- rtl/gac_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas allocator package
// Shared constants and types for the glyph atlas column allocator.
// ----------------------------------------------------------------------------
package gac_pkg;

  // Key table depth and the widths that follow from it.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int PLACE_W = 26;
  localparam int DIVA_W  = 17;
  localparam int DIVB_W  = 9;

  // Request kinds.
  localparam logic FUNC_FIND = 1'b0;
  localparam logic FUNC_ADD  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_ATLAS_W = 2'd0;
  localparam logic [1:0] REG_ATLAS_H = 2'd1;
  localparam logic [1:0] REG_COL_W   = 2'd2;
  localparam logic [1:0] REG_ROW_Q   = 2'd3;

  // Search item that walks down the cell row.
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic               hit;
    logic [PLACE_W-1:0] place;
  } tok_t;

  // Write broadcast to all cells.
  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [KEY_W-1:0]   key;
    logic [PLACE_W-1:0] place;
  } wr_t;

endpackage

// ----- rtl/glyph_atlas_column_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas column allocator
// Glyph cache with a column-packed atlas placement engine.
// ----------------------------------------------------------------------------
// An item on the in_ channel is a find (tuser 0) or an add (tuser 1) request;
// each yields one result item on out_, with the hit or success flag and the
// sticky full flag in out_tuser and the eight corner coordinates in out_tdata.
// A find walks its search item down the row of table cells, one cell per
// cycle, into the result register. An add runs three serial divisions (item
// height, column and row number) plus bookkeeping. An add rejected at once
// goes straight to the result; one that finds no space stops after the
// item height division. Items are handled one at a time; the input is ready
// again in the cycle after the result register loads.
// The configuration port takes a write in every cycle; registers must only
// be changed while no item is in flight.
// Reset empties the key table, clears the cursors and the full flag and
// loads the default geometry; no clearing pass is needed.
// A finished result waits in the output register while the receiver stalls;
// the next item is accepted meanwhile but its result waits for that register.
// ----------------------------------------------------------------------------
module glyph_atlas_column_allocator_top (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata: font_id[15:0], glyph_index[31:16], blob_length[47:32],
  // nominal_width[53:48], nominal_height[59:54], zero[63:60]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,
  input  logic         in_tuser,   // func
  // out_tdata: bl_u, bl_v, tl_u, tl_v, br_u, br_v, tr_u, tr_v, 14 bits each
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser,  // ok[0], atlas_full[1]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_addr,
  input  logic [13:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_FIND, S_HGO, S_HDIV, S_COL, S_FIT, S_XGO, S_XDIV, S_YDIV, S_DONE
  } state_t;

  state_t state_r;

  logic [13:0] aw_r, ah_r;
  logic [8:0]  cw_r;
  logic [7:0]  rq_r;

  logic [13:0] col_x_r, row_y_r;
  logic        full_r;
  logic [gac_pkg::CNT_W-1:0] cnt_r;

  logic [gac_pkg::KEY_W-1:0] key_r;
  logic [15:0] len_r;
  logic [5:0]  nw_r, nh_r;
  logic [16:0] h_r;
  logic [13:0] x_r, y_r;
  logic [17:0] adv_r;
  logic [6:0]  colq_r;
  logic        res_ok_r;
  logic [gac_pkg::PLACE_W-1:0] res_place_r;

  logic         out_vld_r;
  logic [111:0] out_data_r;
  logic [1:0]   out_user_r;

  logic [8:0]  w_eff;
  logic [7:0]  q_eff;
  logic        in_acc;
  logic        out_load;
  logic        div_start, div_done;
  logic [gac_pkg::DIVA_W-1:0] div_a, div_q;
  logic [gac_pkg::DIVB_W-1:0] div_b;
  gac_pkg::wr_t  wr;
  gac_pkg::tok_t tok_in, tok_out;
  logic [17:0] row_plus_h;
  logic [14:0] col_plus_w;
  logic [17:0] qm1;
  logic [18:0] ny;
  logic [13:0] ub, vb;

  // Zero width or quantum counts as one.
  assign w_eff = (cw_r == 9'd0) ? 9'd1 : cw_r;
  assign q_eff = (rq_r == 8'd0) ? 8'd1 : rq_r;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // The result register takes a finished result when it is empty or draining.
  assign out_load = (state_r == S_DONE) && (!out_vld_r || out_tready);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_r <= 14'd512;
      ah_r <= 14'd512;
      cw_r <= 9'd64;
      rq_r <= 8'd8;
    end else if (cfg_valid) begin
      case (cfg_addr)
        gac_pkg::REG_ATLAS_W: aw_r <= cfg_data;
        gac_pkg::REG_ATLAS_H: ah_r <= cfg_data;
        gac_pkg::REG_COL_W:   cw_r <= cfg_data[8:0];
        gac_pkg::REG_ROW_Q:   rq_r <= cfg_data[7:0];
        default:              aw_r <= aw_r;
      endcase
    end
  end

  // Launch a find into the cell row on acceptance.
  always_comb begin
    tok_in       = '0;
    tok_in.vld   = in_acc && (in_tuser == gac_pkg::FUNC_FIND);
    tok_in.key   = in_tdata[31:0];
  end

  // Divider operand selection: item height, then column, then row.
  always_comb begin
    div_start = 1'b0;
    div_a     = {1'b0, len_r} + {8'd0, w_eff} - 17'd1;
    div_b     = w_eff;
    case (state_r)
      S_HGO: div_start = 1'b1;
      S_XGO: begin
        div_start = 1'b1;
        div_a     = {3'd0, x_r};
      end
      S_XDIV: begin
        div_start = div_done;
        div_a     = {3'd0, y_r};
        div_b     = {1'b0, q_eff};
      end
      default: div_start = 1'b0;
    endcase
  end

  // New entry write on the last division.
  always_comb begin
    wr.en    = (state_r == S_YDIV) && div_done;
    wr.idx   = cnt_r[gac_pkg::IDX_W-1:0];
    wr.key   = key_r;
    wr.place = {colq_r, div_q[6:0], nw_r, nh_r};
  end

  assign row_plus_h = {4'd0, row_y_r} + {1'b0, h_r};
  assign col_plus_w = {1'b0, col_x_r} + {6'd0, w_eff};
  assign qm1        = {10'd0, q_eff} - 18'd1;
  assign ny         = {5'd0, row_y_r} + {1'b0, adv_r};

  // Corner encoding of the held placement.
  assign ub = {res_place_r[25:19], res_place_r[11:6], 1'b0};
  assign vb = {res_place_r[18:12], res_place_r[5:0], 1'b0};

  gac_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  gac_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .count   (cnt_r),
    .wr      (wr),
    .tok_in  (tok_in),
    .tok_out (tok_out)
  );

  // Request sequencer, allocator state and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      col_x_r   <= '0;
      row_y_r   <= '0;
      full_r    <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (out_vld_r && out_tready && !out_load) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            key_r    <= in_tdata[31:0];
            len_r    <= in_tdata[47:32];
            nw_r     <= in_tdata[53:48];
            nh_r     <= in_tdata[59:54];
            res_ok_r <= 1'b0;
            if (in_tuser == gac_pkg::FUNC_FIND) begin
              state_r <= S_FIND;
            end else if (full_r) begin
              state_r <= S_DONE;
            end else if (cnt_r == gac_pkg::CNT_W'(gac_pkg::TABLE_DEPTH)) begin
              full_r  <= 1'b1;
              state_r <= S_DONE;
            end else begin
              state_r <= S_HGO;
            end
          end
        end
        S_FIND: begin
          if (tok_out.vld) begin
            res_ok_r    <= tok_out.hit;
            res_place_r <= tok_out.place;
            state_r     <= S_DONE;
          end
        end
        S_HGO: state_r <= S_HDIV;
        S_HDIV: begin
          if (div_done) begin
            h_r     <= div_q;
            state_r <= S_COL;
          end
        end
        // Move to the next column when the item does not fit below the cursor.
        S_COL: begin
          if (row_plus_h > {4'd0, ah_r}) begin
            col_x_r <= 14'({1'b0, col_x_r} + {6'd0, cw_r});
            row_y_r <= '0;
          end
          state_r <= S_FIT;
        end
        S_FIT: begin
          if ((col_plus_w <= {1'b0, aw_r}) && (row_plus_h <= {4'd0, ah_r})) begin
            x_r     <= col_x_r;
            y_r     <= row_y_r;
            adv_r   <= ({1'b0, h_r} + qm1) & ~qm1;
            state_r <= S_XGO;
          end else begin
            full_r  <= 1'b1;
            state_r <= S_DONE;
          end
        end
        // Advance the row cursor, saturating at the top code.
        S_XGO: begin
          row_y_r <= (ny > 19'h3FFF) ? 14'h3FFF : ny[13:0];
          state_r <= S_XDIV;
        end
        S_XDIV: begin
          if (div_done) begin
            colq_r  <= div_q[6:0];
            state_r <= S_YDIV;
          end
        end
        S_YDIV: begin
          if (div_done) begin
            cnt_r       <= cnt_r + 1'b1;
            res_ok_r    <= 1'b1;
            res_place_r <= wr.place;
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_vld_r  <= 1'b1;
            out_user_r <= {full_r, res_ok_r};
            if (res_ok_r) begin
              out_data_r <= {vb | 14'd1, ub | 14'd1, vb, ub | 14'd1,
                             vb | 14'd1, ub, vb, ub};
            end else begin
              out_data_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  // The fill count never passes the table depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= gac_pkg::CNT_W'(gac_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // Once set, the full flag stays set.
  assert property (@(posedge clk) disable iff (!rst_n)
    full_r |=> full_r)
    else $error("full flag dropped");

  // A search item leaves the cell row only while a find is waiting for it.
  assert property (@(posedge clk) disable iff (!rst_n)
    tok_out.vld |-> (state_r == S_FIND))
    else $error("search item out of turn");

  // A table write always bumps the fill count by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("write without count update");
`endif

endmodule

// ----- rtl/gac_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, for unsigned operands.
// ----------------------------------------------------------------------------
module gac_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [gac_pkg::DIVA_W-1:0] dividend,
  input  logic [gac_pkg::DIVB_W-1:0] divisor,
  output logic                       done,
  output logic [gac_pkg::DIVA_W-1:0] quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [4:0]                 step_r;
  logic [gac_pkg::DIVB_W:0]   rem_r;
  logic [gac_pkg::DIVA_W-1:0] quo_r;
  logic [gac_pkg::DIVB_W-1:0] dvs_r;
  logic [gac_pkg::DIVB_W:0]   trial;
  logic                       ge;

  // Shift the next dividend bit into the partial remainder.
  assign trial = {rem_r[gac_pkg::DIVB_W-1:0], quo_r[gac_pkg::DIVA_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  // One restoring step per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? (trial - {1'b0, dvs_r}) : trial;
        quo_r  <= {quo_r[gac_pkg::DIVA_W-2:0], ge};
        step_r <= step_r + 5'd1;
        if (step_r == 5'(gac_pkg::DIVA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/gac_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key table cell
// Holds one key and placement and compares a passing search item with it.
// ----------------------------------------------------------------------------
module gac_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gac_pkg::IDX_W-1:0] cell_idx,
  input  logic [gac_pkg::CNT_W-1:0] count,
  input  gac_pkg::wr_t              wr,
  input  gac_pkg::tok_t             tok_in,
  output gac_pkg::tok_t             tok_out
);

  logic [gac_pkg::KEY_W-1:0]   key_r;
  logic [gac_pkg::PLACE_W-1:0] place_r;
  gac_pkg::tok_t               tok_r;
  gac_pkg::tok_t               tok_nxt;
  logic                        live;

  // Only entries below the fill count take part in a search.
  assign live = {1'b0, cell_idx} < count;

  // The first live matching cell marks the item as hit.
  always_comb begin
    tok_nxt = tok_in;
    if (tok_in.vld && !tok_in.hit && live && (key_r == tok_in.key)) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.place = place_r;
    end
  end

  // Entry storage, written by index.
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      key_r   <= wr.key;
      place_r <= wr.place;
    end
  end

  // Hand the search item to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/gac_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key table cell row
// A row of table cells; a search item moves one cell per cycle.
// ----------------------------------------------------------------------------
module gac_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [gac_pkg::CNT_W-1:0] count,
  input  gac_pkg::wr_t              wr,
  input  gac_pkg::tok_t             tok_in,
  output gac_pkg::tok_t             tok_out
);

  gac_pkg::tok_t link [gac_pkg::TABLE_DEPTH+1];

  assign link[0] = tok_in;

  // Cells in insertion order, entry 0 first.
  for (genvar g = 0; g < gac_pkg::TABLE_DEPTH; g++) begin : g_cell
    gac_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (gac_pkg::IDX_W'(g)),
      .count    (count),
      .wr       (wr),
      .tok_in   (link[g]),
      .tok_out  (link[g+1])
    );
  end

  assign tok_out = link[gac_pkg::TABLE_DEPTH];

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Glyph atlas column allocator testbench
// Sends find and add requests through the stream ports and checks every
// result item field by field against a behavioral model of the glyph cache
// and the column packing cursor. A short table of directed requests comes
// first, then random traffic over several atlas geometries, with bursty
// input, a stalling receiver and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD   = 3000;

  // One result item: hit or success flag, full flag, eight packed corners.
  typedef struct packed {
    logic         ok;
    logic         full;
    logic [111:0] corners;
  } glyph_res_t;

  // A directed request, with its result typed in where it is obvious.
  typedef struct {
    logic        func;
    logic [15:0] font;
    logic [15:0] glyph;
    logic [15:0] len;
    logic [5:0]  nw;
    logic [5:0]  nh;
    bit          typed;
    glyph_res_t  res;
  } dir_row_t;

  // One atlas geometry and the traffic run under it.
  typedef struct {
    int unsigned aw, ah, cw, rq;
    int          n_items;
    bit          wide_len;
    bit          huge_ok;
  } geom_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic         in_tuser = gac_pkg::FUNC_FIND;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_addr = gac_pkg::REG_ATLAS_W;
  logic [13:0]  cfg_data = '0;

  // Model state: geometry registers, cursors, key and placement tables.
  int unsigned  atlas_w, atlas_h, col_w, row_q;
  int unsigned  cur_x, cur_y;
  logic         atlas_full;
  int           n_entries;
  logic [31:0]  key_tab[gac_pkg::TABLE_DEPTH];
  logic [25:0]  place_tab[gac_pkg::TABLE_DEPTH];

  glyph_res_t   pending[$];
  logic [31:0]  known_keys[$];
  int           errors = 0;
  int           cycles = 0;
  int           results_seen = 0;
  int           n_adds = 0;
  int           n_finds = 0;
  int           n_placed = 0;
  int           burst_left = 0;
  int           hold_left = 0;
  bit           hold_done = 0;
  bit           overflow_route;

  dir_row_t dir_tab[12] = '{
    // Empty table: a find misses.
    '{gac_pkg::FUNC_FIND, 16'h0000, 16'h0000, 16'd0, 6'd0, 6'd0, 1,
      '{1'b0, 1'b0, 112'h0}},
    // Zero-high item at the origin with the largest nominal size.
    '{gac_pkg::FUNC_ADD, 16'h0000, 16'h0000, 16'd0, 6'd63, 6'd63, 1,
      '{1'b1, 1'b0, {14'h7F, 14'h7F, 14'h7E, 14'h7F, 14'h7F, 14'h7E, 14'h7E, 14'h7E}}},
    // Row cursor stayed at zero, so this one lands there too.
    '{gac_pkg::FUNC_ADD, 16'hFFFF, 16'hFFFF, 16'd1, 6'd0, 6'd0, 1,
      '{1'b1, 1'b0, {14'h1, 14'h1, 14'h0, 14'h1, 14'h1, 14'h0, 14'h0, 14'h0}}},
    '{gac_pkg::FUNC_FIND, 16'h0000, 16'h0000, 16'd0, 6'd0, 6'd0, 0,
      '{1'b0, 1'b0, 112'h0}},
    // Duplicate key; a find must still return the first one.
    '{gac_pkg::FUNC_ADD, 16'h0000, 16'h0000, 16'd512, 6'd1, 6'd1, 0,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_FIND, 16'h0000, 16'h0000, 16'hFFFF, 6'd63, 6'd63, 0,
      '{1'b0, 1'b0, 112'h0}},
    // Full column height: moves to the next column.
    '{gac_pkg::FUNC_ADD, 16'h1234, 16'h5678, 16'd32768, 6'd21, 6'd42, 0,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_ADD, 16'hA5A5, 16'h5A5A, 16'd1, 6'd42, 6'd21, 0,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_FIND, 16'hFFFF, 16'hFFFF, 16'd0, 6'd0, 6'd0, 0,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_FIND, 16'h1234, 16'h5678, 16'd0, 6'd0, 6'd0, 0,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_FIND, 16'h5678, 16'h1234, 16'd0, 6'd0, 6'd0, 1,
      '{1'b0, 1'b0, 112'h0}},
    '{gac_pkg::FUNC_FIND, 16'hA5A5, 16'h5A5A, 16'd0, 6'd0, 6'd0, 0,
      '{1'b0, 1'b0, 112'h0}}
  };

  glyph_atlas_column_allocator_top DUT (.*);

  // Free-running clock and the run-time limit.
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Expands a stored placement into the eight corner coordinates.
  function automatic logic [111:0] corners_of(logic [25:0] place);
    logic [13:0] ub, vb;
    ub = {place[25:19], place[11:6], 1'b0};
    vb = {place[18:12], place[5:0], 1'b0};
    return {vb | 14'd1, ub | 14'd1, vb, ub | 14'd1, vb | 14'd1, ub, vb, ub};
  endfunction

  // Looks up or places one glyph and updates the cache state.
  function automatic glyph_res_t cache_step(logic func, logic [15:0] font, glyph, len,
                                            logic [5:0] nw, nh);
    glyph_res_t  r;
    logic [31:0] key;
    int unsigned w, q, h, x, y, adv, ny, place;
    r = '0;
    key = {font, glyph};
    w = (col_w != 0) ? col_w : 1;
    q = (row_q != 0) ? row_q : 1;
    if (func == gac_pkg::FUNC_FIND) begin
      for (int i = 0; i < n_entries; i++) begin
        if (key_tab[i] == key) begin
          r.ok = 1'b1;
          r.corners = corners_of(place_tab[i]);
          break;
        end
      end
      r.full = atlas_full;
      return r;
    end
    if (atlas_full) begin
      r.full = 1'b1;
      return r;
    end
    if (n_entries >= gac_pkg::TABLE_DEPTH) begin
      atlas_full = 1'b1;
      r.full = 1'b1;
      return r;
    end
    h = (len + w - 1) / w;
    // Item does not fit below the cursor: start the next column.
    if (cur_y + h > atlas_h) begin
      cur_x = (cur_x + col_w) & 32'h3FFF;
      cur_y = 0;
    end
    if (!(cur_x + w <= atlas_w && cur_y + h <= atlas_h)) begin
      atlas_full = 1'b1;
      r.full = 1'b1;
      return r;
    end
    x = cur_x;
    y = cur_y;
    adv = (h + q - 1) & ~(q - 1);
    ny = cur_y + adv;
    cur_y = (ny > 32'h3FFF) ? 32'h3FFF : ny;
    place = (((x / w) & 32'h7F) << 19) | (((y / q) & 32'h7F) << 12) | (nw << 6) | nh;
    key_tab[n_entries] = key;
    place_tab[n_entries] = place[25:0];
    n_entries++;
    n_placed++;
    r.ok = 1'b1;
    r.full = atlas_full;
    r.corners = corners_of(place[25:0]);
    return r;
  endfunction

  task automatic report(string what, logic [111:0] got, logic [111:0] want);
    $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Queues one expected result item behind the others.
  task automatic expect_res(glyph_res_t r);
    pending = {pending, r};
  endtask

  // Offers one request in bursts and predicts it once it is accepted.
  task automatic send_req(logic func, logic [15:0] font, glyph, len,
                          logic [5:0] nw, nh, output glyph_res_t res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= {4'b0, nh, nw, len, glyph, font};
    do @(posedge clk); while (!in_tready);
    if (func == gac_pkg::FUNC_ADD) begin
      n_adds++;
      known_keys = {known_keys, {font, glyph}};
    end else begin
      n_finds++;
    end
    res = cache_step(func, font, glyph, len, nw, nh);
  endtask

  // Writes one register; the caller drops cfg_valid after the last write.
  task automatic write_reg(logic [1:0] addr, int unsigned value);
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= value[13:0];
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      gac_pkg::REG_ATLAS_W: atlas_w = value & 32'h3FFF;
      gac_pkg::REG_ATLAS_H: atlas_h = value & 32'h3FFF;
      gac_pkg::REG_COL_W:   col_w   = value & 32'h1FF;
      default:              row_q   = value & 32'hFF;
    endcase
  endtask

  // Long output hold-off, counted down on its own.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (rst_n && !hold_done && results_seen >= 40) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
    end
  end

  // Receiver: changing stall patterns, held off during the long hold.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
    end else begin
      case ((cycles / 700) % 3)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker: each result item against the oldest expectation.
  always @(posedge clk) begin
    glyph_res_t want;
    string      names[8];
    names = '{"bl_u", "bl_v", "tl_u", "tl_v", "br_u", "br_v", "tr_u", "tr_v"};
    if (rst_n && out_tvalid && out_tready) begin
      results_seen <= results_seen + 1;
      if (pending.size() == 0) begin
        report("unexpected result item", out_tdata, '0);
      end else begin
        want = pending.pop_front();
        if (out_tuser[0] !== want.ok)
          report("ok", 112'(out_tuser[0]), 112'(want.ok));
        if (out_tuser[1] !== want.full)
          report("atlas_full", 112'(out_tuser[1]), 112'(want.full));
        for (int k = 0; k < 8; k++) begin
          if (out_tdata[14*k +: 14] !== want.corners[14*k +: 14])
            report(names[k], 112'(out_tdata[14*k +: 14]), 112'(want.corners[14*k +: 14]));
        end
      end
    end
  end

  // Stimulus.
  initial begin
    glyph_res_t  res;
    geom_t       geoms[6];
    logic        func;
    logic [15:0] font, glyph, len;
    logic [31:0] key;
    int unsigned w;
    atlas_w = 512; atlas_h = 512; col_w = 64; row_q = 8;
    cur_x = 0; cur_y = 0; atlas_full = 1'b0; n_entries = 0;
    // Per seed, the full flag comes either from running out of space
    // or from filling the key table.
    overflow_route = 1'($urandom_range(0, 1));
    geoms = '{
      '{8192, 8192, 256, 128, 150, 1, 0},
      '{1000, 700, 7, 3, 150, 0, overflow_route},
      '{8192, 8192, 0, 0, 150, 0, 0},
      '{8192, 8192, 1, 1, 240, 0, 0},
      '{1, 1, 1, 1, 100, 0, 0},
      '{512, 512, 64, 8, 150, 0, 1}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset geometry.
    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].func, dir_tab[i].font, dir_tab[i].glyph, dir_tab[i].len,
               dir_tab[i].nw, dir_tab[i].nh, res);
      expect_res(dir_tab[i].typed ? dir_tab[i].res : res);
    end

    // Random traffic, one geometry after another.
    foreach (geoms[g]) begin
      in_tvalid <= 1'b0;
      while (pending.size() != 0) @(posedge clk);
      repeat (8) @(posedge clk);
      write_reg(gac_pkg::REG_ATLAS_W, geoms[g].aw);
      write_reg(gac_pkg::REG_ATLAS_H, geoms[g].ah);
      write_reg(gac_pkg::REG_COL_W, geoms[g].cw);
      write_reg(gac_pkg::REG_ROW_Q, geoms[g].rq);
      cfg_valid <= 1'b0;
      w = (col_w != 0) ? col_w : 1;
      repeat (geoms[g].n_items) begin
        func = ($urandom_range(0, 9) < 4) ? gac_pkg::FUNC_ADD : gac_pkg::FUNC_FIND;
        key = $urandom();
        if (known_keys.size() != 0 &&
            $urandom_range(0, 9) < (func == gac_pkg::FUNC_ADD ? 2 : 5))
          key = known_keys[$urandom_range(0, known_keys.size() - 1)];
        {font, glyph} = key;
        if (geoms[g].wide_len || (geoms[g].huge_ok && $urandom_range(0, 29) == 0))
          len = 16'($urandom_range(0, 16'hFFFF));
        else
          len = 16'($urandom_range(0, w * 16));
        send_req(func, font, glyph, len, 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)), res);
        expect_res(res);
      end
    end

    in_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Ran %0d finds and %0d adds over six atlas geometries; %0d glyphs placed.",
             n_finds, n_adds, n_placed);
    $display("Table entries: %0d, atlas full at end: %0d, long output hold-off: %0d.",
             n_entries, atlas_full, hold_done);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/gac_pkg.sv
rtl/gac_div.sv
rtl/gac_cell.sv
rtl/gac_chain.sv
rtl/glyph_atlas_column_allocator_top.sv
tb/sv/testbench.sv
